// File: sv/swm_pkg.sv
// Shared types and constants for the sliding window maximum block.
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 7;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // Input transfer payload
    typedef struct packed {
        t_sample sample;
        logic    sample_last;
    } t_in;

    // Output transfer payload
    typedef struct packed {
        t_sample window_max;
        logic    max_last;
    } t_out;

    // Per-cycle control broadcast to every deque cell
    typedef struct packed {
        logic    pop;    // shift the chain one cell toward the front
        logic    fin;    // a sample is taken and merged this cycle
        logic    clear;  // run ends: empty the chain after the merge
        t_sample smp;    // sample being merged
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: sv/swm_cell.sv
// One deque entry: holds value and position, compares, shifts and loads.
`default_nettype none

module swm_cell #(
    parameter int POS_BITS = 7,
    parameter int WIN_BITS = 7,
    parameter int POS_WRAP = 128
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  swm_pkg::t_cell_ctl        i_ctl,
    input  wire  [POS_BITS-1:0]       i_pc,
    input  wire  [WIN_BITS-1:0]       i_win,
    input  wire                       i_prev_keep,
    input  wire                       i_nxt_vld,
    input  swm_pkg::t_sample          i_nxt_val,
    input  wire  [POS_BITS-1:0]       i_nxt_pos,
    input  wire                       i_nxt_ge,
    output logic                      o_vld,
    output swm_pkg::t_sample          o_val,
    output logic [POS_BITS-1:0]       o_pos,
    output logic                      o_ge,
    output logic                      o_exp,
    output logic                      o_keep
);
    import swm_pkg::*;

    logic                r_vld;
    t_sample             r_val;
    logic [POS_BITS-1:0] r_pos;
    logic                n_vld;
    t_sample             n_val;
    logic [POS_BITS-1:0] n_pos;
    logic [POS_BITS:0]   age;

    assign o_vld = r_vld;
    assign o_val = r_val;
    assign o_pos = r_pos;

    // Age of the held entry, modulo the position wrap
    always_comb begin
        age = {1'b0, i_pc} - {1'b0, r_pos};
        if (i_pc < r_pos) begin
            age = {1'b0, i_pc} + (POS_BITS+1)'(POS_WRAP) - {1'b0, r_pos};
        end
    end

    assign o_exp  = r_vld && (age >= (POS_BITS+1)'(i_win));
    assign o_ge   = r_vld && (r_val >= i_ctl.smp);
    assign o_keep = i_ctl.pop ? i_nxt_ge : o_ge;

    // Merge: keep the surviving entry, load the new sample right after the last
    // survivor, drop everything behind it
    always_comb begin
        n_vld = r_vld;
        n_val = r_val;
        n_pos = r_pos;
        if (i_ctl.fin) begin
            if (o_keep) begin
                n_vld = 1'b1;
                n_val = i_ctl.pop ? i_nxt_val : r_val;
                n_pos = i_ctl.pop ? i_nxt_pos : r_pos;
            end else if (i_prev_keep) begin
                n_vld = 1'b1;
                n_val = i_ctl.smp;
                n_pos = i_pc;
            end else begin
                n_vld = 1'b0;
            end
            if (i_ctl.clear) begin
                n_vld = 1'b0;
            end
        end else if (i_ctl.pop) begin
            n_vld = i_nxt_vld;
            n_val = i_nxt_val;
            n_pos = i_nxt_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_val <= n_val;
        r_pos <= n_pos;
    end

endmodule

`default_nettype wire

// File: sv/sliding_window_maximum.sv
// Top level: running maximum over a sliding window, deque kept in a chain of cells.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+--------------------------
//  in       | i_in_valid / o_in_stall        | i_in  (sample, sample_last)
//  out      | o_out_valid / i_out_stall      | o_out (window_max, max_last)
//  cfg      | i_cfg_valid / o_cfg_ready      | i_cfg_data (window_size)
//
// One sample per cycle in steady state while the output is not stalled; a result
// is registered and appears in the cycle after its sample is taken. After the
// window is made shorter, the first sample waits while each further expired front
// entry is shifted out, as the chain shifts one cell per cycle while the output is
// not stalled. Reset empties the chain at once and sets the window to 1. The input
// stalls while the output register holds a result that is itself stalled.
`default_nettype none

module sliding_window_maximum #(
    parameter int WINDOW_MAX = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  swm_pkg::t_in                 i_in,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output swm_pkg::t_out                o_out,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [swm_pkg::CFG_BITS-1:0] i_cfg_data
);
    import swm_pkg::*;

    localparam int POS_WRAP = 2 * WINDOW_MAX;
    localparam int POS_BITS = $clog2(POS_WRAP);
    localparam int WIN_BITS = $clog2(WINDOW_MAX + 1);

    logic [CFG_BITS-1:0] r_win_cfg;
    logic [POS_BITS-1:0] r_pc;
    logic [POS_BITS-1:0] n_pc;
    logic [WIN_BITS-1:0] r_fill;
    logic [WIN_BITS-1:0] n_fill;
    logic                r_out_vld;
    t_out                r_out;

    logic [31:0]         cfg_wide;
    logic [31:0]         win_wide;
    logic [WIN_BITS-1:0] win;
    logic                out_free;
    logic                act;
    logic                emit;
    t_sample             front;
    t_cell_ctl           ctl;

    logic                c_vld  [WINDOW_MAX];
    t_sample             c_val  [WINDOW_MAX];
    logic [POS_BITS-1:0] c_pos  [WINDOW_MAX];
    logic                c_ge   [WINDOW_MAX];
    logic                c_exp  [WINDOW_MAX];
    logic                c_keep [WINDOW_MAX];

    // Clamp the configured window into 1..WINDOW_MAX
    always_comb begin
        cfg_wide = 32'(r_win_cfg);
        win_wide = cfg_wide;
        if (cfg_wide == 32'd0) begin
            win_wide = 32'd1;
        end else if (cfg_wide > 32'(WINDOW_MAX)) begin
            win_wide = 32'(WINDOW_MAX);
        end
        win = WIN_BITS'(win_wide);
    end

    // Handshake: finish a sample unless two or more front entries still expire
    assign out_free    = !r_out_vld || !i_out_stall;
    assign act         = i_in_valid && out_free;
    assign ctl.pop     = act && c_exp[0];
    assign ctl.fin     = act && !(c_exp[0] && c_exp[1]);
    assign ctl.clear   = i_in.sample_last;
    assign ctl.smp     = i_in.sample;
    assign o_in_stall  = !(out_free && !(c_exp[0] && c_exp[1]));
    assign o_cfg_ready = 1'b1;

    // Build the chain
    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic                prev_keep;
        logic                nxt_vld;
        t_sample             nxt_val;
        logic [POS_BITS-1:0] nxt_pos;
        logic                nxt_ge;

        if (i == 0) begin : g_head
            assign prev_keep = 1'b1;
        end else begin : g_body
            assign prev_keep = c_keep[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_tail
            assign nxt_vld = 1'b0;
            assign nxt_val = '0;
            assign nxt_pos = '0;
            assign nxt_ge  = 1'b0;
        end else begin : g_link
            assign nxt_vld = c_vld[i+1];
            assign nxt_val = c_val[i+1];
            assign nxt_pos = c_pos[i+1];
            assign nxt_ge  = c_ge[i+1];
        end

        swm_cell #(
            .POS_BITS (POS_BITS),
            .WIN_BITS (WIN_BITS),
            .POS_WRAP (POS_WRAP)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_pc        (r_pc),
            .i_win       (win),
            .i_prev_keep (prev_keep),
            .i_nxt_vld   (nxt_vld),
            .i_nxt_val   (nxt_val),
            .i_nxt_pos   (nxt_pos),
            .i_nxt_ge    (nxt_ge),
            .o_vld       (c_vld[i]),
            .o_val       (c_val[i]),
            .o_pos       (c_pos[i]),
            .o_ge        (c_ge[i]),
            .o_exp       (c_exp[i]),
            .o_keep      (c_keep[i])
        );
    end

    // Front after the merge
    always_comb begin
        front = i_in.sample;
        if (c_keep[0]) begin
            front = ctl.pop ? c_val[1] : c_val[0];
        end
    end

    // Advance run counters
    always_comb begin
        n_fill = r_fill;
        if (r_fill < WIN_BITS'(WINDOW_MAX)) begin
            n_fill = r_fill + WIN_BITS'(1);
        end
        n_pc = r_pc + POS_BITS'(1);
        if (r_pc == POS_BITS'(POS_WRAP - 1)) begin
            n_pc = '0;
        end
    end

    assign emit = n_fill >= win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cfg <= CFG_BITS'(1);
            r_pc      <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_win_cfg <= i_cfg_data;
            end
            if (ctl.fin) begin
                r_out_vld <= emit;
                if (i_in.sample_last) begin
                    r_pc   <= '0;
                    r_fill <= '0;
                end else begin
                    r_pc   <= n_pc;
                    r_fill <= n_fill;
                end
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
        // Load the result payload
        if (ctl.fin) begin
            r_out.window_max <= front;
            r_out.max_last   <= i_in.sample_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: sim/sliding_window_maximum_tb.sv
// Self-checking testbench for the sliding window maximum block.
`default_nettype none

module sliding_window_maximum_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int WINDOW_MAX    = 64;
    localparam int RANDOM_ITEMS  = 340;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;

    // Sample patterns used for one run
    typedef enum int {
        PAT_NOISE,
        PAT_NARROW,
        PAT_RISING,
        PAT_FALLING,
        PAT_EXTREME
    } t_pattern;

    // Predicts the running window maximum and checks what the block returns
    class WindowMaxScoreboard;
        t_sample        front_vals[WINDOW_MAX];
        logic [6:0]     front_pos[WINDOW_MAX];
        int             held;
        logic [6:0]     next_pos;
        int             filled;
        logic [6:0]     window_reg;
        t_out           expected_maxima[$];
        int             mismatches;
        int             samples_taken;
        int             maxima_checked;

        function new();
            held           = 0;
            next_pos       = '0;
            filled         = 0;
            window_reg     = 7'd1;
            mismatches     = 0;
            samples_taken  = 0;
            maxima_checked = 0;
        endfunction

        function void set_window(logic [6:0] value);
            window_reg = value;
        endfunction

        function void drop_oldest();
            for (int i = 0; i < held - 1; i++) begin
                front_vals[i] = front_vals[i+1];
                front_pos[i]  = front_pos[i+1];
            end
            held--;
        endfunction

        // Advance the deque by one accepted sample and queue any result
        function void take_sample(t_in item);
            int         span;
            logic [6:0] age;
            t_out       result;
            span = (window_reg == 0) ? 1 :
                   (window_reg > WINDOW_MAX) ? WINDOW_MAX : int'(window_reg);
            samples_taken++;
            // Expire every front entry that has left the window
            while (held > 0) begin
                age = next_pos - front_pos[0];
                if (int'(age) < span)
                    break;
                drop_oldest();
            end
            // Drop smaller tail entries; equal ones stay
            while (held > 0 && front_vals[held-1] < item.sample)
                held--;
            if (held >= WINDOW_MAX)
                drop_oldest();
            front_vals[held] = item.sample;
            front_pos[held]  = next_pos;
            held++;
            if (filled < WINDOW_MAX)
                filled++;
            if (filled >= span) begin
                result.window_max = front_vals[0];
                result.max_last   = item.sample_last;
                expected_maxima   = {expected_maxima, result};
            end
            next_pos++;
            if (item.sample_last) begin
                held     = 0;
                next_pos = '0;
                filled   = 0;
            end
        endfunction

        function void compare_result(t_out got);
            t_out want;
            if (expected_maxima.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result max=%0d last=%0b",
                             $realtime, got.window_max, got.max_last);
                return;
            end
            want = expected_maxima[0];
            expected_maxima.delete(0);
            maxima_checked++;
            if (got.window_max !== want.window_max || got.max_last !== want.max_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result %0d expected max=%0d last=%0b got max=%0d last=%0b",
                             $realtime, maxima_checked, want.window_max, want.max_last,
                             got.window_max, got.max_last);
            end
        endfunction

        function int pending();
            return expected_maxima.size();
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in                 i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out                o_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_BITS-1:0] i_cfg_data  = '0;

    WindowMaxScoreboard sb = new();

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    bit   hold_request  = 1'b0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    int   window_writes = 0;
    int   runs_closed   = 0;

    // Run state carried across segments so a run can span a window change
    int       run_len  = 0;
    int       run_pos  = 0;
    t_pattern run_pat  = PAT_NOISE;
    t_sample  run_base = '0;

    sliding_window_maximum #(
        .WINDOW_MAX (WINDOW_MAX)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Check every output transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.compare_result(o_out);
    end

    // Count cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("sliding_window_maximum: mismatch");
        $finish;
    end

    // Offer one sample and hold it until the block takes it
    task automatic send_sample(t_sample value, logic last);
        t_in item;
        item.sample      = value;
        item.sample_last = last;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do
            @(posedge i_clk);
        while (o_in_stall);
        sb.take_sample(item);
        if (last)
            runs_closed++;
    endtask

    // Wait until every result is back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(logic [CFG_BITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_window(value);
        window_writes++;
    endtask

    function automatic t_sample pattern_sample(t_pattern pat, t_sample base, int idx);
        case (pat)
            PAT_NOISE:   return t_sample'($urandom());
            PAT_NARROW:  return t_sample'($urandom_range(0, 8)) - 16'sd4;
            PAT_RISING:  return base + t_sample'(idx * 37);
            PAT_FALLING: return base - t_sample'(idx * 37);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
        endcase
    endfunction

    // Send a stream of runs with random lengths around the window size
    task automatic send_stream(int count, int span);
        for (int n = 0; n < count; n++) begin
            if (run_pos >= run_len) begin
                run_pos  = 0;
                run_len  = ($urandom_range(0, 3) != 0) ? $urandom_range(span, 2 * span + 4)
                                                       : $urandom_range(1, span);
                run_pat  = t_pattern'($urandom_range(0, 4));
                run_base = t_sample'($urandom());
            end
            send_sample(pattern_sample(run_pat, run_base, run_pos), run_pos + 1 == run_len);
            run_pos++;
        end
    endtask

    initial begin
        int sent;
        int seg;
        int phase;
        int win;
        int span;
        int n_items;
        int idle_by_phase[4];
        int stall_by_phase[4];
        idle_by_phase  = '{0, 87, 0, 38};
        stall_by_phase = '{0, 0, 87, 38};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Window of one after reset: extremes pass straight through
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shFFFF, 1'b1);
        drain();

        // Equal values stay in the deque; then a short run emits nothing
        write_window(7'd3);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(-16'sd3, 1'b1);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b1);
        drain();

        // Zero window acts as one
        write_window(7'd0);
        send_sample(16'sd9, 1'b0);
        send_sample(-16'sd9, 1'b1);
        drain();

        // Shrink the window mid-run so several front entries expire at once
        write_window(7'd4);
        for (int i = 0; i < 6; i++)
            send_sample(t_sample'(10 - i), 1'b0);
        drain();
        write_window(7'd2);
        send_sample(16'sd4, 1'b0);
        send_sample(16'sd3, 1'b1);
        drain();

        // Hold the receiver off while the sender keeps offering samples
        write_window(7'd2);
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_sample(t_sample'($urandom()), i == 39);
        drain();

        // Random segments, each with its own window, across the idling phases
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            phase         = (sent * 4 / RANDOM_ITEMS < 3) ? sent * 4 / RANDOM_ITEMS : 3;
            send_idle_pct = idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            if (seg == 2)
                win = 64;
            else if (seg == 5)
                win = 127;
            else if ($urandom_range(0, 9) != 0)
                win = $urandom_range(1, 8);
            else
                win = $urandom_range(9, 70);
            span = (win == 0) ? 1 : (win > WINDOW_MAX) ? WINDOW_MAX : win;
            write_window(CFG_BITS'(win));
            if (span > 8)
                n_items = $urandom_range(span + 5, 2 * span + 10);
            else
                n_items = $urandom_range(10, 30);
            send_stream(n_items, span);
            sent += n_items;
            drain();
            seg++;
        end
        send_idle_pct = 0;
        stall_pct     = 0;

        drain();
        $display("%0d samples in %0d closed runs, %0d window writes, %0d maxima checked",
                 sb.samples_taken, runs_closed, window_writes, sb.maxima_checked);
        $display("idling phases: none, sender, receiver, both; one long receiver hold-off");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("sliding_window_maximum: match");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
            $display("sliding_window_maximum: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
